/* src/bma_pkg.sv */
// Package for the battery monitor averager: field widths, scaling and
// averaging constants, register codes and the beat types of both channels.
// No dependencies.
package bma_pkg;

  // Ring depth and raw converter resolution
  localparam int AVERAGE_DEPTH = 4;
  localparam int RAW_BITS      = 10;

  // Fixed widths of the channel fields
  localparam int IN_W    = 10;
  localparam int VOLT_W  = 8;
  localparam int CUR_W   = 9;
  localparam int LEVEL_W = 8;
  localparam int CH      = 4;

  // Raw bits actually taken from each input field
  localparam int RAW_USE_W = (RAW_BITS < IN_W) ? RAW_BITS : IN_W;

  // Scaled sample width, set by the largest scaled current
  localparam int SAMPLE_W = $clog2(((2 ** RAW_USE_W) - 1) / 3 + 1);
  localparam int SUM_W    = SAMPLE_W + $clog2(AVERAGE_DEPTH);
  localparam int PTR_W    = (AVERAGE_DEPTH > 1) ? $clog2(AVERAGE_DEPTH) : 1;

  // Divide by 5 (scale 20/100) and by 3 as multiply by rounded-up reciprocal
  localparam int VOLT_SHIFT = RAW_USE_W + 3;
  localparam int VOLT_RECIP = ((2 ** VOLT_SHIFT) + 4) / 5;
  localparam int CUR_SHIFT  = RAW_USE_W + 2;
  localparam int CUR_RECIP  = ((2 ** CUR_SHIFT) + 2) / 3;
  localparam int SCALE_PW   = RAW_USE_W + VOLT_SHIFT + 1;

  // Divide the ring sum by the depth the same way
  localparam int AVG_SHIFT = SUM_W + $clog2(AVERAGE_DEPTH);
  localparam int AVG_RECIP = ((2 ** AVG_SHIFT) + AVERAGE_DEPTH - 1) / AVERAGE_DEPTH;
  localparam int AVG_PW    = SUM_W + AVG_SHIFT + 1;

  // Width for compares and output clamping
  localparam int EXT_W = SAMPLE_W + 10;

  // Channel slots in the rings
  localparam int CH_IN_V  = 0;
  localparam int CH_IN_I  = 1;
  localparam int CH_OUT_V = 2;
  localparam int CH_OUT_I = 3;

  // Configuration register indexes and reset values
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_SET   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_CLEAR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EMPTY      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MARGIN     = 2'd3;

  localparam logic [LEVEL_W-1:0] FULL_SET_RESET   = 8'd137;
  localparam logic [LEVEL_W-1:0] FULL_CLEAR_RESET = 8'd134;
  localparam logic [LEVEL_W-1:0] EMPTY_RESET      = 8'd114;
  localparam logic [LEVEL_W-1:0] MARGIN_RESET     = 8'd1;

  typedef struct packed {
    logic [IN_W-1:0] raw_in_voltage;
    logic [IN_W-1:0] raw_in_current;
    logic [IN_W-1:0] raw_out_voltage;
    logic [IN_W-1:0] raw_out_current;
  } sample_t;

  typedef struct packed {
    logic [VOLT_W-1:0] avg_in_voltage;
    logic [CUR_W-1:0]  avg_in_current;
    logic [VOLT_W-1:0] avg_out_voltage;
    logic [CUR_W-1:0]  avg_out_current;
    logic              charging;
    logic              battery_full;
    logic              battery_empty;
  } result_t;

endpackage

/* src/battery_monitor_averager.sv */
// Battery monitor averager top level: scaling, four-sample rings, averages
// and flags. Depends on bma_pkg.
//
// One sample beat (four raw 10-bit readings) gives one result beat via the
// stage one and result registers; one beat per cycle is taken unless the
// result is stalled. The first stage scales voltages by 20/100 and
// currents by 1/3; the second writes each scaled value into its channel's
// 4-entry ring, keeps a running ring sum, divides it by four and derives
// the charging, full (with hysteresis between the set and clear levels)
// and empty flags. The rings start at zero after reset, so the first three
// averages include zero entries. Both stages hold while the result beat is
// stalled; sample_stall is raised only then. Configuration writes are always
// taken (cfg_ready is high) and should be done while no beat is in flight.
module battery_monitor_averager (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              sample_valid,
  output logic                              sample_stall,
  input  bma_pkg::sample_t                  sample,
  output logic                              result_valid,
  input  logic                              result_stall,
  output bma_pkg::result_t                  result,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bma_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bma_pkg::LEVEL_W-1:0]       cfg_data
);

  // Configuration registers
  logic [bma_pkg::LEVEL_W-1:0] full_set_level;
  logic [bma_pkg::LEVEL_W-1:0] full_clear_level;
  logic [bma_pkg::LEVEL_W-1:0] empty_level;
  logic [bma_pkg::LEVEL_W-1:0] charge_margin;

  // Pipeline control
  logic advance;
  logic scaled_valid;

  // Stage one: scaled samples
  logic [bma_pkg::SAMPLE_W-1:0] scaled [bma_pkg::CH];
  logic [bma_pkg::SAMPLE_W-1:0] scaled_next [bma_pkg::CH];
  logic [bma_pkg::RAW_USE_W-1:0] raw [bma_pkg::CH];
  logic [bma_pkg::SCALE_PW-1:0]  scale_prod [bma_pkg::CH];

  // Stage two: rings, running sums, hysteresis flag
  logic [bma_pkg::SAMPLE_W-1:0] ring [bma_pkg::CH][bma_pkg::AVERAGE_DEPTH];
  logic [bma_pkg::SUM_W-1:0]    sum [bma_pkg::CH];
  logic [bma_pkg::SUM_W-1:0]    sum_next [bma_pkg::CH];
  logic [bma_pkg::AVG_PW-1:0]   avg_prod [bma_pkg::CH];
  logic [bma_pkg::EXT_W-1:0]    avg_ext [bma_pkg::CH];
  logic [bma_pkg::PTR_W-1:0]    pos;
  logic [bma_pkg::PTR_W-1:0]    pos_next;
  logic                         full;
  logic                         full_next;
  bma_pkg::result_t             result_next;

  // Clamp an average to an output field of the given width
  function automatic logic [bma_pkg::CUR_W-1:0] clamp_out(
    input logic [bma_pkg::EXT_W-1:0] value,
    input int                        width
  );
    logic [bma_pkg::EXT_W-1:0] top;
    top = (bma_pkg::EXT_W'(1) << width) - bma_pkg::EXT_W'(1);
    clamp_out = (value > top) ? top[bma_pkg::CUR_W-1:0] : value[bma_pkg::CUR_W-1:0];
  endfunction

  assign cfg_ready    = 1'b1;
  assign advance      = !(result_valid && result_stall);
  assign sample_stall = !advance;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      full_set_level   <= bma_pkg::FULL_SET_RESET;
      full_clear_level <= bma_pkg::FULL_CLEAR_RESET;
      empty_level      <= bma_pkg::EMPTY_RESET;
      charge_margin    <= bma_pkg::MARGIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bma_pkg::REG_FULL_SET:   full_set_level   <= cfg_data;
        bma_pkg::REG_FULL_CLEAR: full_clear_level <= cfg_data;
        bma_pkg::REG_EMPTY:      empty_level      <= cfg_data;
        bma_pkg::REG_MARGIN:     charge_margin    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Scale raw readings: voltages divide by 5, currents by 3
  always_comb begin
    raw[bma_pkg::CH_IN_V]  = sample.raw_in_voltage[bma_pkg::RAW_USE_W-1:0];
    raw[bma_pkg::CH_IN_I]  = sample.raw_in_current[bma_pkg::RAW_USE_W-1:0];
    raw[bma_pkg::CH_OUT_V] = sample.raw_out_voltage[bma_pkg::RAW_USE_W-1:0];
    raw[bma_pkg::CH_OUT_I] = sample.raw_out_current[bma_pkg::RAW_USE_W-1:0];
    for (int c = 0; c < bma_pkg::CH; c++) begin
      if (c == bma_pkg::CH_IN_V || c == bma_pkg::CH_OUT_V) begin
        scale_prod[c] = bma_pkg::SCALE_PW'(raw[c]) *
                        bma_pkg::SCALE_PW'(bma_pkg::VOLT_RECIP);
        scaled_next[c] = scale_prod[c][bma_pkg::VOLT_SHIFT +: bma_pkg::SAMPLE_W];
      end else begin
        scale_prod[c] = bma_pkg::SCALE_PW'(raw[c]) *
                        bma_pkg::SCALE_PW'(bma_pkg::CUR_RECIP);
        scaled_next[c] = scale_prod[c][bma_pkg::CUR_SHIFT +: bma_pkg::SAMPLE_W];
      end
    end
  end

  // Stage one register
  always_ff @(posedge clk) begin
    if (rst) begin
      scaled_valid <= 1'b0;
    end else if (advance) begin
      scaled_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int c = 0; c < bma_pkg::CH; c++) begin
        scaled[c] <= scaled_next[c];
      end
    end
  end

  // Update running sums, divide by depth, derive flags
  always_comb begin
    for (int c = 0; c < bma_pkg::CH; c++) begin
      sum_next[c] = sum[c] - bma_pkg::SUM_W'(ring[c][pos]) + bma_pkg::SUM_W'(scaled[c]);
      avg_prod[c] = bma_pkg::AVG_PW'(sum_next[c]) * bma_pkg::AVG_PW'(bma_pkg::AVG_RECIP);
      avg_ext[c]  = bma_pkg::EXT_W'(avg_prod[c][bma_pkg::AVG_SHIFT +: bma_pkg::SAMPLE_W]);
    end

    pos_next = (pos == bma_pkg::PTR_W'(bma_pkg::AVERAGE_DEPTH - 1)) ?
               '0 : pos + bma_pkg::PTR_W'(1);

    // Clearing wins when both levels trip
    full_next = full;
    if (avg_ext[bma_pkg::CH_OUT_V] > bma_pkg::EXT_W'(full_set_level)) begin
      full_next = 1'b1;
    end
    if (avg_ext[bma_pkg::CH_OUT_V] < bma_pkg::EXT_W'(full_clear_level)) begin
      full_next = 1'b0;
    end

    result_next.avg_in_voltage  =
      bma_pkg::VOLT_W'(clamp_out(avg_ext[bma_pkg::CH_IN_V], bma_pkg::VOLT_W));
    result_next.avg_in_current  = clamp_out(avg_ext[bma_pkg::CH_IN_I], bma_pkg::CUR_W);
    result_next.avg_out_voltage =
      bma_pkg::VOLT_W'(clamp_out(avg_ext[bma_pkg::CH_OUT_V], bma_pkg::VOLT_W));
    result_next.avg_out_current = clamp_out(avg_ext[bma_pkg::CH_OUT_I], bma_pkg::CUR_W);
    result_next.charging        = avg_ext[bma_pkg::CH_IN_I] >
                                  (avg_ext[bma_pkg::CH_OUT_I] +
                                   bma_pkg::EXT_W'(charge_margin));
    result_next.battery_full    = full_next;
    result_next.battery_empty   = avg_ext[bma_pkg::CH_OUT_V] <
                                  bma_pkg::EXT_W'(empty_level);
  end

  // Stage two state: rings, sums, write slot, full flag
  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= '0;
      full <= 1'b0;
      for (int c = 0; c < bma_pkg::CH; c++) begin
        sum[c] <= '0;
        for (int k = 0; k < bma_pkg::AVERAGE_DEPTH; k++) begin
          ring[c][k] <= '0;
        end
      end
    end else if (advance && scaled_valid) begin
      pos  <= pos_next;
      full <= full_next;
      for (int c = 0; c < bma_pkg::CH; c++) begin
        sum[c]       <= sum_next[c];
        ring[c][pos] <= scaled[c];
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= scaled_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && scaled_valid) begin
      result <= result_next;
    end
  end

  // Sum of one channel's ring, for checking the running sum
  function automatic logic [bma_pkg::SUM_W-1:0] ring_total(input int c);
    logic [bma_pkg::SUM_W-1:0] acc;
    acc = '0;
    for (int k = 0; k < bma_pkg::AVERAGE_DEPTH; k++) begin
      acc = acc + bma_pkg::SUM_W'(ring[c][k]);
    end
    ring_total = acc;
  endfunction

  // Running sums track the ring contents
  a_sum_in_cur: assert property (@(posedge clk) disable iff (rst)
    sum[bma_pkg::CH_IN_I] == ring_total(bma_pkg::CH_IN_I))
    else $error("input current running sum out of step with ring");

  a_sum_out_volt: assert property (@(posedge clk) disable iff (rst)
    sum[bma_pkg::CH_OUT_V] == ring_total(bma_pkg::CH_OUT_V))
    else $error("output voltage running sum out of step with ring");

  // Write slot stays within the ring
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos <= bma_pkg::PTR_W'(bma_pkg::AVERAGE_DEPTH - 1))
    else $error("ring write slot out of range");

  // A shown result carries the current hysteresis state
  a_full_match: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.battery_full == full)
    else $error("full flag in result differs from held state");

  // Samples are stalled only by a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> !sample_stall)
    else $error("sample stalled with no result waiting");

endmodule

/* bench/battery_monitor_averager_tb.sv */
// Testbench for battery_monitor_averager: directed and random sample beats
// checked against a local predictor of the averages and flags.
// Depends on bma_pkg and the battery_monitor_averager RTL.
module battery_monitor_averager_tb;

  logic                          clk          = 1'b0;
  logic                          rst          = 1'b1;
  logic                          sample_valid = 1'b0;
  logic                          sample_stall;
  bma_pkg::sample_t              sample_beat  = '0;
  logic                          result_valid;
  logic                          result_stall = 1'b0;
  bma_pkg::result_t              result_beat;
  logic                          cfg_valid    = 1'b0;
  logic                          cfg_ready;
  logic [bma_pkg::CFG_IDX_W-1:0] cfg_index    = bma_pkg::REG_FULL_SET;
  logic [bma_pkg::LEVEL_W-1:0]   cfg_data     = '0;

  // Predictor copy of the rings, write slot, full flag and levels
  logic [bma_pkg::SAMPLE_W-1:0] ring_history [bma_pkg::CH][bma_pkg::AVERAGE_DEPTH];
  int                           ring_slot;
  logic                         full_state;
  logic [bma_pkg::LEVEL_W-1:0]  set_level;
  logic [bma_pkg::LEVEL_W-1:0]  clear_level;
  logic [bma_pkg::LEVEL_W-1:0]  empty_level;
  logic [bma_pkg::LEVEL_W-1:0]  margin;

  bma_pkg::sample_t pending_samples[$];
  bma_pkg::result_t expected_results[$];
  bma_pkg::result_t want_beat;
  int      errors        = 0;
  bit      idle_on       = 1'b1;
  bit      pressure_go   = 1'b0;
  logic    receiver_hold = 1'b0;
  int      send_gap      = 0;
  int      recv_gap      = 0;

  battery_monitor_averager dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample_beat),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result_beat),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Scale one reading set, push it into the rings, return averages and flags
  function automatic bma_pkg::result_t average_and_flag(bma_pkg::sample_t s);
    int               scaled [bma_pkg::CH];
    int               avg [bma_pkg::CH];
    int               sum;
    int               raw_mask;
    bma_pkg::result_t r;
    raw_mask = (1 << bma_pkg::RAW_BITS) - 1;
    scaled[bma_pkg::CH_IN_V]  = ((s.raw_in_voltage & raw_mask) * 20) / 100;
    scaled[bma_pkg::CH_IN_I]  = (s.raw_in_current & raw_mask) / 3;
    scaled[bma_pkg::CH_OUT_V] = ((s.raw_out_voltage & raw_mask) * 20) / 100;
    scaled[bma_pkg::CH_OUT_I] = (s.raw_out_current & raw_mask) / 3;
    for (int c = 0; c < bma_pkg::CH; c++) begin
      ring_history[c][ring_slot] = scaled[c][bma_pkg::SAMPLE_W-1:0];
      sum = 0;
      for (int k = 0; k < bma_pkg::AVERAGE_DEPTH; k++)
        sum += ring_history[c][k];
      avg[c] = sum / bma_pkg::AVERAGE_DEPTH;
    end
    ring_slot = (ring_slot + 1 >= bma_pkg::AVERAGE_DEPTH) ? 0 : ring_slot + 1;

    // Clear wins when both levels are crossed at once
    if (avg[bma_pkg::CH_OUT_V] > set_level)
      full_state = 1'b1;
    if (avg[bma_pkg::CH_OUT_V] < clear_level)
      full_state = 1'b0;

    // Saturate averages wider than their fields; flags use the full value
    r.avg_in_voltage  = (avg[bma_pkg::CH_IN_V] > 2**bma_pkg::VOLT_W - 1) ? '1 :
                        avg[bma_pkg::CH_IN_V][bma_pkg::VOLT_W-1:0];
    r.avg_in_current  = (avg[bma_pkg::CH_IN_I] > 2**bma_pkg::CUR_W - 1) ? '1 :
                        avg[bma_pkg::CH_IN_I][bma_pkg::CUR_W-1:0];
    r.avg_out_voltage = (avg[bma_pkg::CH_OUT_V] > 2**bma_pkg::VOLT_W - 1) ? '1 :
                        avg[bma_pkg::CH_OUT_V][bma_pkg::VOLT_W-1:0];
    r.avg_out_current = (avg[bma_pkg::CH_OUT_I] > 2**bma_pkg::CUR_W - 1) ? '1 :
                        avg[bma_pkg::CH_OUT_I][bma_pkg::CUR_W-1:0];
    r.charging        = (avg[bma_pkg::CH_IN_I] > avg[bma_pkg::CH_OUT_I] + margin);
    r.battery_full    = full_state;
    r.battery_empty   = (avg[bma_pkg::CH_OUT_V] < empty_level);
    return r;
  endfunction

  function automatic logic [bma_pkg::IN_W-1:0] to_raw(int v);
    if (v < 0)
      v = 0;
    if (v > 2**bma_pkg::IN_W - 1)
      v = 2**bma_pkg::IN_W - 1;
    return v[bma_pkg::IN_W-1:0];
  endfunction

  // Mostly readings near the current levels and margin, some fully random
  function automatic bma_pkg::sample_t random_reading();
    bma_pkg::sample_t s;
    int               lvl;
    s.raw_in_voltage  = $urandom_range(0, 2**bma_pkg::IN_W - 1);
    s.raw_out_current = $urandom_range(0, 2**bma_pkg::IN_W - 1);
    if ($urandom_range(0, 3) == 0) begin
      s.raw_in_current  = $urandom_range(0, 2**bma_pkg::IN_W - 1);
      s.raw_out_voltage = $urandom_range(0, 2**bma_pkg::IN_W - 1);
    end else begin
      case ($urandom_range(0, 2))
        0:       lvl = set_level;
        1:       lvl = clear_level;
        default: lvl = empty_level;
      endcase
      s.raw_out_voltage = to_raw(lvl * 5 + $urandom_range(0, 100) - 50);
      s.raw_in_current  = to_raw(s.raw_out_current + margin * 3 +
                                 $urandom_range(0, 60) - 30);
    end
    return s;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  task automatic queue_reading(int n, int iv, int ii, int ov, int oi);
    bma_pkg::sample_t s;
    s.raw_in_voltage  = iv[bma_pkg::IN_W-1:0];
    s.raw_in_current  = ii[bma_pkg::IN_W-1:0];
    s.raw_out_voltage = ov[bma_pkg::IN_W-1:0];
    s.raw_out_current = oi[bma_pkg::IN_W-1:0];
    repeat (n) pending_samples.push_back(s);
  endtask

  task automatic queue_random(int n);
    repeat (n) pending_samples.push_back(random_reading());
  endtask

  // Hold until every queued beat is sent and every result has come back
  task automatic wait_idle();
    while (pending_samples.size() != 0 || sample_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [bma_pkg::CFG_IDX_W-1:0] idx,
                           logic [bma_pkg::LEVEL_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      bma_pkg::REG_FULL_SET:   set_level   = value;
      bma_pkg::REG_FULL_CLEAR: clear_level = value;
      bma_pkg::REG_EMPTY:      empty_level = value;
      bma_pkg::REG_MARGIN:     margin      = value;
      default: ;
    endcase
  endtask

  task automatic set_levels(int s, int c, int e, int m);
    wait_idle();
    write_reg(bma_pkg::REG_FULL_SET, s[bma_pkg::LEVEL_W-1:0]);
    write_reg(bma_pkg::REG_FULL_CLEAR, c[bma_pkg::LEVEL_W-1:0]);
    write_reg(bma_pkg::REG_EMPTY, e[bma_pkg::LEVEL_W-1:0]);
    write_reg(bma_pkg::REG_MARGIN, m[bma_pkg::LEVEL_W-1:0]);
  endtask

  // Drive sample beats from the pending queue; predict each accepted beat
  always @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else begin
      if (sample_valid && !sample_stall)
        expected_results.push_back(average_and_flag(sample_beat));
      if (!sample_valid || !sample_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          sample_valid <= 1'b0;
        end else if (pending_samples.size() > 0) begin
          sample_beat  <= pending_samples.pop_front();
          sample_valid <= 1'b1;
          if (idle_on && $urandom_range(0, 5) == 0)
            send_gap = $urandom_range(1, 4);
        end else begin
          sample_valid <= 1'b0;
        end
      end
    end
  end

  // Check result beats in order and stall the output in random bursts
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          $error("result beat with nothing expected: %p", result_beat);
          errors++;
        end else begin
          want_beat = expected_results.pop_front();
          check_field("avg_in_voltage", want_beat.avg_in_voltage, result_beat.avg_in_voltage);
          check_field("avg_in_current", want_beat.avg_in_current, result_beat.avg_in_current);
          check_field("avg_out_voltage", want_beat.avg_out_voltage,
                      result_beat.avg_out_voltage);
          check_field("avg_out_current", want_beat.avg_out_current,
                      result_beat.avg_out_current);
          check_field("charging", want_beat.charging, result_beat.charging);
          check_field("battery_full", want_beat.battery_full, result_beat.battery_full);
          check_field("battery_empty", want_beat.battery_empty, result_beat.battery_empty);
        end
      end
      if (recv_gap > 0)
        recv_gap--;
      else if (idle_on && $urandom_range(0, 5) == 0)
        recv_gap = $urandom_range(1, 4);
      result_stall <= receiver_hold || (recv_gap > 0);
    end
  end

  // Long output hold so the pipeline fills and backs up the input
  initial begin
    wait (pressure_go);
    @(posedge clk);
    receiver_hold <= 1'b1;
    repeat (80) @(posedge clk);
    receiver_hold <= 1'b0;
  end

  initial begin
    #2000000;
    $display("battery_monitor_averager_tb: FAIL");
    $finish;
  end

  initial begin
    for (int c = 0; c < bma_pkg::CH; c++)
      for (int k = 0; k < bma_pkg::AVERAGE_DEPTH; k++)
        ring_history[c][k] = '0;
    ring_slot   = 0;
    full_state  = 1'b0;
    set_level   = bma_pkg::FULL_SET_RESET;
    clear_level = bma_pkg::FULL_CLEAR_RESET;
    empty_level = bma_pkg::EMPTY_RESET;
    margin      = bma_pkg::MARGIN_RESET;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Warm-up with field extremes and alternating bit patterns
    queue_reading(1, 0, 0, 0, 0);
    queue_reading(1, 1023, 1023, 1023, 1023);
    queue_reading(1, 'h2AA, 'h2AA, 'h2AA, 'h2AA);
    queue_reading(1, 'h155, 'h155, 'h155, 'h155);
    // Climb above the set level, sit in the hysteresis band, fall to empty;
    // input current well above, at, then just above output current plus margin
    queue_reading(4, 500, 600, 700, 300);
    queue_reading(4, 400, 303, 675, 300);
    queue_reading(4, 300, 306, 560, 300);
    queue_reading(4, 300, 306, 500, 300);

    set_levels(200, 180, 150, 10);
    queue_random(400);

    // Crossed levels: clear wins inside the overlap
    set_levels(100, 150, 50, 0);
    queue_reading(4, 0, 3, 600, 0);
    queue_reading(4, 0, 0, 900, 0);
    queue_random(200);

    set_levels(0, 0, 0, 0);
    queue_random(150);

    set_levels(255, 255, 255, 255);
    queue_random(150);

    // Output held off while inputs keep coming, then a full drain
    set_levels(bma_pkg::FULL_SET_RESET, bma_pkg::FULL_CLEAR_RESET,
               bma_pkg::EMPTY_RESET, bma_pkg::MARGIN_RESET);
    queue_random(300);
    pressure_go = 1'b1;
    wait_idle();

    // Closing stretch at full rate
    set_levels(160, 120, 100, 5);
    idle_on = 1'b0;
    queue_random(300);

    while (pending_samples.size() != 0 || sample_valid)
      @(posedge clk);
    for (int n = 0; n < 200 && expected_results.size() != 0; n++)
      @(posedge clk);
    repeat (8) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d expected result beats never arrived", expected_results.size());
      errors++;
    end
    if (errors == 0)
      $display("battery_monitor_averager_tb: PASS");
    else
      $display("battery_monitor_averager_tb: FAIL");
    $finish;
  end

endmodule
